### rtl/core/eihf_pkg.sv
// Shared constants for the Ethernet/IPv4/L4 header filter: verdict codes,
// byte offsets, protocol numbers and configuration register indexes.
// No dependencies.
`default_nettype none

package eihf_pkg;

    // Verdict codes carried on the result channel.
    localparam logic [3:0] VERDICT_NOT_IPV4   = 4'd0;
    localparam logic [3:0] VERDICT_SRC_MISS   = 4'd1;
    localparam logic [3:0] VERDICT_DST_MISS   = 4'd2;
    localparam logic [3:0] VERDICT_NOT_L4     = 4'd3;
    localparam logic [3:0] VERDICT_FRAGMENT   = 4'd4;
    localparam logic [3:0] VERDICT_SPORT_MISS = 4'd5;
    localparam logic [3:0] VERDICT_DPORT_MISS = 4'd6;
    localparam logic [3:0] VERDICT_TCP_OK     = 4'd7;
    localparam logic [3:0] VERDICT_UDP_OK     = 4'd8;
    localparam logic [3:0] VERDICT_TRUNCATED  = 4'd9;

    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_IP_SOURCE_MATCH   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IP_DEST_MATCH     = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_PORT_MATCH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_PORT_MATCH   = 8'd3;

    // Byte offsets within the frame, counted from the destination MAC.
    localparam logic [5:0] POS_MAC_SRC_FIRST = 6'd6;
    localparam logic [5:0] POS_ETYPE_FIRST   = 6'd12;
    localparam logic [5:0] POS_ETYPE_LAST    = 6'd13;
    localparam logic [5:0] POS_VERSION_IHL   = 6'd14;
    localparam logic [5:0] POS_TOTLEN_HI     = 6'd16;
    localparam logic [5:0] POS_TOTLEN_LO     = 6'd17;
    localparam logic [5:0] POS_FRAG_HI       = 6'd20;
    localparam logic [5:0] POS_FRAG_LO       = 6'd21;
    localparam logic [5:0] POS_TTL           = 6'd22;
    localparam logic [5:0] POS_PROTO         = 6'd23;
    localparam logic [5:0] POS_IP_SRC_FIRST  = 6'd26;
    localparam logic [5:0] POS_IP_SRC_LAST   = 6'd29;
    localparam logic [5:0] POS_IP_DST_FIRST  = 6'd30;
    localparam logic [5:0] POS_IP_DST_LAST   = 6'd33;
    localparam logic [5:0] POS_SPORT_LAST    = 6'd35;
    localparam logic [5:0] POS_DPORT_LAST    = 6'd37;
    localparam logic [5:0] POS_UDP_LEN_HI    = 6'd38;
    localparam logic [5:0] POS_UDP_LEN_LO    = 6'd39;
    localparam logic [5:0] POS_TCP_FLAGS     = 6'd47;
    localparam logic [5:0] POS_MAX           = 6'd63;

endpackage

`default_nettype wire

### rtl/core/eth_ipv4_l4_header_filter_core.sv
// Top level of the Ethernet/IPv4/L4 header filter: byte capture, filter
// checks and the result register. Depends on eihf_pkg.
// The result of a request marked frame_end is registered and shows on m_* in the next cycle.
// Throughput: one byte per cycle; a byte is held off only when it ends a frame
// while the previous result still sits unaccepted in the result register.
// Reset (aresetn low, synchronous) clears the filters, the frame state and
// the result valid flag.
`default_nettype none

module eth_ipv4_l4_header_filter_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_frame_end,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_verdict,
    output logic [47:0]      m_mac_destination,
    output logic [47:0]      m_mac_source,
    output logic [15:0]      m_ether_type,
    output logic [7:0]       m_version_ihl,
    output logic [15:0]      m_total_length,
    output logic [12:0]      m_fragment_offset,
    output logic [15:0]      m_ttl_and_protocol,
    output logic [31:0]      m_ip_source,
    output logic [31:0]      m_ip_dest,
    output logic [31:0]      m_port_pair,
    output logic [15:0]      m_transport_info
);

    // Filter registers. Configuration writes are always taken.
    logic [31:0] ip_source_match_reg;
    logic [31:0] ip_dest_match_reg;
    logic [15:0] source_port_match_reg;
    logic [15:0] dest_port_match_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_source_match_reg   <= '0;
            ip_dest_match_reg     <= '0;
            source_port_match_reg <= '0;
            dest_port_match_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                eihf_pkg::CFG_IP_SOURCE_MATCH:   ip_source_match_reg   <= cfg_data;
                eihf_pkg::CFG_IP_DEST_MATCH:     ip_dest_match_reg     <= cfg_data;
                eihf_pkg::CFG_SOURCE_PORT_MATCH: source_port_match_reg <= cfg_data[15:0];
                eihf_pkg::CFG_DEST_PORT_MATCH:   dest_port_match_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // An IP filter is only armed when none of its four octets is zero.
    logic ip_src_active;
    logic ip_dst_active;
    assign ip_src_active = (|ip_source_match_reg[31:24]) && (|ip_source_match_reg[23:16]) &&
                           (|ip_source_match_reg[15:8])  && (|ip_source_match_reg[7:0]);
    assign ip_dst_active = (|ip_dest_match_reg[31:24]) && (|ip_dest_match_reg[23:16]) &&
                           (|ip_dest_match_reg[15:8])  && (|ip_dest_match_reg[7:0]);

    // Per-frame state.
    logic [5:0]  pos_reg,       pos_next;
    logic        decided_reg,   decided_next;
    logic [3:0]  verdict_reg,   verdict_next;
    logic [47:0] mac_dst_reg,   mac_dst_next;
    logic [47:0] mac_src_reg,   mac_src_next;
    logic [15:0] etype_reg,     etype_next;
    logic [7:0]  vihl_reg,      vihl_next;
    logic [15:0] totlen_reg,    totlen_next;
    logic [12:0] frag_reg,      frag_next;
    logic [15:0] ttlproto_reg,  ttlproto_next;
    logic [31:0] ip_src_reg,    ip_src_next;
    logic [31:0] ip_dst_reg,    ip_dst_next;
    logic [31:0] ports_reg,     ports_next;
    logic [15:0] transport_reg, transport_next;

    logic [7:0] proto_old;
    logic [7:0] proto_new;
    logic       proto_is_l4;

    assign proto_old   = ttlproto_reg[7:0];
    assign proto_new   = ttlproto_next[7:0];
    assign proto_is_l4 = (proto_new == eihf_pkg::PROTO_TCP) ||
                         (proto_new == eihf_pkg::PROTO_UDP);

    // Capture of the current byte, then the check tied to its offset. The
    // checks look at the fields as they stand after this byte is captured.
    always_comb begin
        mac_dst_next   = mac_dst_reg;
        mac_src_next   = mac_src_reg;
        etype_next     = etype_reg;
        vihl_next      = vihl_reg;
        totlen_next    = totlen_reg;
        frag_next      = frag_reg;
        ttlproto_next  = ttlproto_reg;
        ip_src_next    = ip_src_reg;
        ip_dst_next    = ip_dst_reg;
        ports_next     = ports_reg;
        transport_next = transport_reg;
        decided_next   = decided_reg;
        verdict_next   = verdict_reg;

        if (!decided_reg) begin
            if (pos_reg < eihf_pkg::POS_MAC_SRC_FIRST) begin
                mac_dst_next = {mac_dst_reg[39:0], s_data_byte};
            end else if (pos_reg < eihf_pkg::POS_ETYPE_FIRST) begin
                mac_src_next = {mac_src_reg[39:0], s_data_byte};
            end else if (pos_reg <= eihf_pkg::POS_ETYPE_LAST) begin
                etype_next = {etype_reg[7:0], s_data_byte};
            end else if (pos_reg == eihf_pkg::POS_VERSION_IHL) begin
                vihl_next = s_data_byte;
            end else if (pos_reg == eihf_pkg::POS_TOTLEN_HI ||
                         pos_reg == eihf_pkg::POS_TOTLEN_LO) begin
                totlen_next = {totlen_reg[7:0], s_data_byte};
            end else if (pos_reg == eihf_pkg::POS_FRAG_HI ||
                         pos_reg == eihf_pkg::POS_FRAG_LO) begin
                frag_next = {frag_reg[4:0], s_data_byte};
            end else if (pos_reg == eihf_pkg::POS_TTL || pos_reg == eihf_pkg::POS_PROTO) begin
                ttlproto_next = {ttlproto_reg[7:0], s_data_byte};
            end else if (pos_reg >= eihf_pkg::POS_IP_SRC_FIRST &&
                         pos_reg <= eihf_pkg::POS_IP_SRC_LAST) begin
                ip_src_next = {ip_src_reg[23:0], s_data_byte};
            end else if (pos_reg >= eihf_pkg::POS_IP_DST_FIRST &&
                         pos_reg <= eihf_pkg::POS_IP_DST_LAST) begin
                ip_dst_next = {ip_dst_reg[23:0], s_data_byte};
            end else if (pos_reg > eihf_pkg::POS_IP_DST_LAST &&
                         pos_reg <= eihf_pkg::POS_DPORT_LAST) begin
                ports_next = {ports_reg[23:0], s_data_byte};
            end else if ((pos_reg == eihf_pkg::POS_UDP_LEN_HI ||
                          pos_reg == eihf_pkg::POS_UDP_LEN_LO) &&
                         proto_old == eihf_pkg::PROTO_UDP) begin
                transport_next = {transport_reg[7:0], s_data_byte};
            end else if (pos_reg == eihf_pkg::POS_TCP_FLAGS &&
                         proto_old == eihf_pkg::PROTO_TCP) begin
                // ACK lands in bit 1, SYN in bit 0.
                transport_next = {14'd0, s_data_byte[4], s_data_byte[1]};
            end

            case (pos_reg)
                eihf_pkg::POS_ETYPE_LAST: begin
                    if (etype_next != eihf_pkg::ETHERTYPE_IPV4) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_NOT_IPV4;
                    end
                end
                eihf_pkg::POS_IP_SRC_LAST: begin
                    if (ip_src_active && ip_src_next != ip_source_match_reg) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_SRC_MISS;
                    end
                end
                eihf_pkg::POS_IP_DST_LAST: begin
                    // Protocol check outranks the fragment check.
                    if (ip_dst_active && ip_dst_next != ip_dest_match_reg) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_DST_MISS;
                    end else if (!proto_is_l4) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_NOT_L4;
                    end else if (frag_next != 13'd0) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_FRAGMENT;
                    end
                end
                eihf_pkg::POS_SPORT_LAST: begin
                    if (source_port_match_reg != 16'd0 &&
                        ports_next[15:0] != source_port_match_reg) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_SPORT_MISS;
                    end
                end
                eihf_pkg::POS_DPORT_LAST: begin
                    if (dest_port_match_reg != 16'd0 &&
                        ports_next[15:0] != dest_port_match_reg) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_DPORT_MISS;
                    end
                end
                eihf_pkg::POS_UDP_LEN_LO: begin
                    if (proto_new == eihf_pkg::PROTO_UDP) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_UDP_OK;
                    end
                end
                eihf_pkg::POS_TCP_FLAGS: begin
                    if (proto_new == eihf_pkg::PROTO_TCP) begin
                        decided_next = 1'b1;
                        verdict_next = eihf_pkg::VERDICT_TCP_OK;
                    end
                end
                default: ;
            endcase
        end

        pos_next = (pos_reg == eihf_pkg::POS_MAX) ? pos_reg : pos_reg + 6'd1;
    end

    // A byte that ends a frame needs a free result register; any other byte
    // is always taken, even while a result waits downstream.
    logic m_valid_reg;
    logic s_accept;
    logic frame_done;

    assign s_ready    = !m_valid_reg || m_ready || !s_frame_end;
    assign s_accept   = s_valid && s_ready;
    assign frame_done = s_accept && s_frame_end;

    // Frame state: advances on every accepted byte and is cleared after the
    // byte that ends the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn || frame_done) begin
            pos_reg       <= '0;
            decided_reg   <= 1'b0;
            verdict_reg   <= eihf_pkg::VERDICT_TRUNCATED;
            mac_dst_reg   <= '0;
            mac_src_reg   <= '0;
            etype_reg     <= '0;
            vihl_reg      <= '0;
            totlen_reg    <= '0;
            frag_reg      <= '0;
            ttlproto_reg  <= '0;
            ip_src_reg    <= '0;
            ip_dst_reg    <= '0;
            ports_reg     <= '0;
            transport_reg <= '0;
        end else if (s_accept) begin
            pos_reg       <= pos_next;
            decided_reg   <= decided_next;
            verdict_reg   <= verdict_next;
            mac_dst_reg   <= mac_dst_next;
            mac_src_reg   <= mac_src_next;
            etype_reg     <= etype_next;
            vihl_reg      <= vihl_next;
            totlen_reg    <= totlen_next;
            frag_reg      <= frag_next;
            ttlproto_reg  <= ttlproto_next;
            ip_src_reg    <= ip_src_next;
            ip_dst_reg    <= ip_dst_next;
            ports_reg     <= ports_next;
            transport_reg <= transport_next;
        end
    end

    // Result register: valid flag under reset, payload loaded at frame end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (frame_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            m_verdict          <= verdict_next;
            m_mac_destination  <= mac_dst_next;
            m_mac_source       <= mac_src_next;
            m_ether_type       <= etype_next;
            m_version_ihl      <= vihl_next;
            m_total_length     <= totlen_next;
            m_fragment_offset  <= frag_next;
            m_ttl_and_protocol <= ttlproto_next;
            m_ip_source        <= ip_src_next;
            m_ip_dest          <= ip_dst_next;
            m_port_pair        <= ports_next;
            m_transport_info   <= transport_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/core/eihf_checker.sv
// Port-level checker for the header filter core, bound to the top level.
// Depends on eihf_pkg and eth_ipv4_l4_header_filter_core.
`default_nettype none

module eihf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_verdict,
    input wire logic [15:0] m_ether_type,
    input wire logic [15:0] m_ttl_and_protocol
);

    // A stalled result keeps its verdict.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict))
        else $error("result changed while stalled");

    // No result comes out of reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_verdict <= eihf_pkg::VERDICT_TRUNCATED)
        else $error("verdict code out of range");

    // A pass verdict implies an IPv4 frame with the matching protocol.
    a_tcp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict == eihf_pkg::VERDICT_TCP_OK |->
            m_ether_type == eihf_pkg::ETHERTYPE_IPV4 &&
            m_ttl_and_protocol[7:0] == eihf_pkg::PROTO_TCP)
        else $error("TCP pass on a non-TCP frame");

    a_udp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_verdict == eihf_pkg::VERDICT_UDP_OK |->
            m_ether_type == eihf_pkg::ETHERTYPE_IPV4 &&
            m_ttl_and_protocol[7:0] == eihf_pkg::PROTO_UDP)
        else $error("UDP pass on a non-UDP frame");

endmodule

bind eth_ipv4_l4_header_filter_core eihf_checker u_eihf_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_verdict          (m_verdict),
    .m_ether_type       (m_ether_type),
    .m_ttl_and_protocol (m_ttl_and_protocol)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking bench for the Ethernet/IPv4/L4 header filter core: builds byte
// streams of frames, predicts each verdict and its captured fields, and checks
// them on the result channel. Depends on eihf_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

    // The run is about a thousand requests, so this limit is very loose.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // Indexes past the register file. The core must ignore writes to them.
    localparam logic [7:0] CFG_INDEX_UNUSED_LO = 8'd4;
    localparam logic [7:0] CFG_INDEX_UNUSED_HI = 8'hFF;
    // Cycles the receiver holds off when it applies back pressure.
    localparam int unsigned LONG_HOLD_CYCLES = 300;

    // One captured header, laid out like the result channel.
    typedef struct packed {
        logic [3:0]  verdict;
        logic [47:0] mac_destination;
        logic [47:0] mac_source;
        logic [15:0] ether_type;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [12:0] fragment_offset;
        logic [15:0] ttl_and_protocol;
        logic [31:0] ip_source;
        logic [31:0] ip_dest;
        logic [31:0] port_pair;
        logic [15:0] transport_info;
    } header_capture_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_frame_end = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_verdict;
    logic [47:0] m_mac_destination;
    logic [47:0] m_mac_source;
    logic [15:0] m_ether_type;
    logic [7:0]  m_version_ihl;
    logic [15:0] m_total_length;
    logic [12:0] m_fragment_offset;
    logic [15:0] m_ttl_and_protocol;
    logic [31:0] m_ip_source;
    logic [31:0] m_ip_dest;
    logic [31:0] m_port_pair;
    logic [15:0] m_transport_info;

    eth_ipv4_l4_header_filter_core u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_frame_end        (s_frame_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_verdict          (m_verdict),
        .m_mac_destination  (m_mac_destination),
        .m_mac_source       (m_mac_source),
        .m_ether_type       (m_ether_type),
        .m_version_ihl      (m_version_ihl),
        .m_total_length     (m_total_length),
        .m_fragment_offset  (m_fragment_offset),
        .m_ttl_and_protocol (m_ttl_and_protocol),
        .m_ip_source        (m_ip_source),
        .m_ip_dest          (m_ip_dest),
        .m_port_pair        (m_port_pair),
        .m_transport_info   (m_transport_info)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter predictor. It keeps its own copy of the filter registers and
    // of the per-frame capture state, and is stepped once per accepted byte.
    // ------------------------------------------------------------------
    logic [31:0] rule_ip_source = '0;
    logic [31:0] rule_ip_dest   = '0;
    logic [15:0] rule_sport     = '0;
    logic [15:0] rule_dport     = '0;

    header_capture_t cap;
    logic [5:0]      cap_pos;
    logic            cap_decided;
    header_capture_t expected_headers[$];

    // An address filter only applies when none of its octets is zero.
    function automatic logic ip_rule_on(input logic [31:0] rule);
        return (|rule[31:24]) && (|rule[23:16]) && (|rule[15:8]) && (|rule[7:0]);
    endfunction

    task automatic start_new_frame();
        cap         = '0;
        cap.verdict = eihf_pkg::VERDICT_TRUNCATED;
        cap_pos     = '0;
        cap_decided = 1'b0;
    endtask

    // The first failing check fixes the verdict; after that nothing more of
    // the frame is captured, which is why later fields of such frames read zero.
    task automatic fix_verdict(input logic [3:0] v);
        cap.verdict = v;
        cap_decided = 1'b1;
    endtask

    task automatic capture_byte(input logic [7:0] b, input logic last);
        logic [7:0] proto;
        if (!cap_decided) begin
            proto = cap.ttl_and_protocol[7:0];
            if (cap_pos < eihf_pkg::POS_MAC_SRC_FIRST)
                cap.mac_destination = {cap.mac_destination[39:0], b};
            else if (cap_pos < eihf_pkg::POS_ETYPE_FIRST)
                cap.mac_source = {cap.mac_source[39:0], b};
            else if (cap_pos <= eihf_pkg::POS_ETYPE_LAST)
                cap.ether_type = {cap.ether_type[7:0], b};
            else if (cap_pos == eihf_pkg::POS_VERSION_IHL)
                cap.version_ihl = b;
            else if (cap_pos == eihf_pkg::POS_TOTLEN_HI || cap_pos == eihf_pkg::POS_TOTLEN_LO)
                cap.total_length = {cap.total_length[7:0], b};
            else if (cap_pos == eihf_pkg::POS_FRAG_HI || cap_pos == eihf_pkg::POS_FRAG_LO)
                // Only the 13 offset bits survive; the flag bits fall off the top.
                cap.fragment_offset = {cap.fragment_offset[4:0], b};
            else if (cap_pos == eihf_pkg::POS_TTL || cap_pos == eihf_pkg::POS_PROTO)
                cap.ttl_and_protocol = {cap.ttl_and_protocol[7:0], b};
            else if (cap_pos >= eihf_pkg::POS_IP_SRC_FIRST &&
                     cap_pos <= eihf_pkg::POS_IP_SRC_LAST)
                cap.ip_source = {cap.ip_source[23:0], b};
            else if (cap_pos >= eihf_pkg::POS_IP_DST_FIRST &&
                     cap_pos <= eihf_pkg::POS_IP_DST_LAST)
                cap.ip_dest = {cap.ip_dest[23:0], b};
            else if (cap_pos > eihf_pkg::POS_IP_DST_LAST &&
                     cap_pos <= eihf_pkg::POS_DPORT_LAST)
                cap.port_pair = {cap.port_pair[23:0], b};
            else if ((cap_pos == eihf_pkg::POS_UDP_LEN_HI ||
                      cap_pos == eihf_pkg::POS_UDP_LEN_LO)
                     && proto == eihf_pkg::PROTO_UDP)
                cap.transport_info = {cap.transport_info[7:0], b};
            else if (cap_pos == eihf_pkg::POS_TCP_FLAGS && proto == eihf_pkg::PROTO_TCP)
                // ACK sits in bit 4 of the flags byte, SYN in bit 1.
                cap.transport_info = {14'd0, b[4], b[1]};

            proto = cap.ttl_and_protocol[7:0];
            case (cap_pos)
                eihf_pkg::POS_ETYPE_LAST: begin
                    if (cap.ether_type != eihf_pkg::ETHERTYPE_IPV4)
                        fix_verdict(eihf_pkg::VERDICT_NOT_IPV4);
                end
                eihf_pkg::POS_IP_SRC_LAST: begin
                    if (ip_rule_on(rule_ip_source) && cap.ip_source != rule_ip_source)
                        fix_verdict(eihf_pkg::VERDICT_SRC_MISS);
                end
                eihf_pkg::POS_IP_DST_LAST: begin
                    // The protocol check comes ahead of the fragment check.
                    if (ip_rule_on(rule_ip_dest) && cap.ip_dest != rule_ip_dest)
                        fix_verdict(eihf_pkg::VERDICT_DST_MISS);
                    else if (proto != eihf_pkg::PROTO_TCP && proto != eihf_pkg::PROTO_UDP)
                        fix_verdict(eihf_pkg::VERDICT_NOT_L4);
                    else if (cap.fragment_offset != '0)
                        fix_verdict(eihf_pkg::VERDICT_FRAGMENT);
                end
                eihf_pkg::POS_SPORT_LAST: begin
                    if (rule_sport != '0 && cap.port_pair[15:0] != rule_sport)
                        fix_verdict(eihf_pkg::VERDICT_SPORT_MISS);
                end
                eihf_pkg::POS_DPORT_LAST: begin
                    if (rule_dport != '0 && cap.port_pair[15:0] != rule_dport)
                        fix_verdict(eihf_pkg::VERDICT_DPORT_MISS);
                end
                eihf_pkg::POS_UDP_LEN_LO: begin
                    if (proto == eihf_pkg::PROTO_UDP) fix_verdict(eihf_pkg::VERDICT_UDP_OK);
                end
                eihf_pkg::POS_TCP_FLAGS: begin
                    if (proto == eihf_pkg::PROTO_TCP) fix_verdict(eihf_pkg::VERDICT_TCP_OK);
                end
                default: ;
            endcase
        end
        if (cap_pos != eihf_pkg::POS_MAX) cap_pos++;
        if (last) begin
            expected_headers.push_back(cap);
            start_new_frame();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and input request tracking, both on the rising edge.
    // Outputs are read before the core's own updates for this edge land.
    // ------------------------------------------------------------------
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    logic        s_taken         = 1'b0;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        header_capture_t want;
        if (!aresetn) begin
            s_taken = 1'b0;
            start_new_frame();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_headers.size() == 0) begin
                    $error("result with no frame outstanding, verdict %0d", m_verdict);
                    mismatch_count++;
                end else begin
                    want = expected_headers.pop_front();
                    check_field("verdict",          want.verdict,          m_verdict);
                    check_field("mac_destination",  want.mac_destination,  m_mac_destination);
                    check_field("mac_source",       want.mac_source,       m_mac_source);
                    check_field("ether_type",       want.ether_type,       m_ether_type);
                    check_field("version_ihl",      want.version_ihl,      m_version_ihl);
                    check_field("total_length",     want.total_length,     m_total_length);
                    check_field("fragment_offset",  want.fragment_offset,  m_fragment_offset);
                    check_field("ttl_and_protocol", want.ttl_and_protocol, m_ttl_and_protocol);
                    check_field("ip_source",        want.ip_source,        m_ip_source);
                    check_field("ip_dest",          want.ip_dest,          m_ip_dest);
                    check_field("port_pair",        want.port_pair,        m_port_pair);
                    check_field("transport_info",   want.transport_info,   m_transport_info);
                end
                results_checked++;
            end
            // A result only shows up in the cycle after its last byte, so pushing the
            // new expectation after the check above never changes its outcome.
            s_taken = s_valid && s_ready;
            if (s_taken) capture_byte(s_data_byte, s_frame_end);
        end
    end

    // ------------------------------------------------------------------
    // Byte driver. Requests come from frame_bytes_todo in bursts of random
    // length separated by random gaps. A gap is only taken between requests,
    // so a raised valid always stays up until its request is accepted.
    // ------------------------------------------------------------------
    frame_byte_t frame_bytes_todo[$];
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin : byte_driver
        frame_byte_t nxt;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_data_byte <= '0;
            s_frame_end <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (frame_bytes_todo.size() != 0) begin
                nxt = frame_bytes_todo.pop_front();
                s_valid     <= 1'b1;
                s_data_byte <= nxt.data;
                s_frame_end <= nxt.last;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    // A quarter of the bursts run straight into the next one.
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver. It cycles through four stall patterns (always ready,
    // coin flip, one cycle in three, mostly ready). After the first few
    // results, and every 50 results after that, it also holds off for a long
    // stretch; the driver keeps sending, so the result register stays full
    // and the core has to refuse the next frame's end.
    // ------------------------------------------------------------------
    int unsigned stall_tick   = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 3;

    always @(negedge aclk) begin : result_receiver
        logic ready_now;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall_tick++;
            if (hold_left == 0 && results_checked >= next_hold_at) begin
                hold_left    = LONG_HOLD_CYCLES;
                next_hold_at = next_hold_at + 50;
            end
            case (stall_tick[8:7])
                2'd0:    ready_now = 1'b1;
                2'd1:    ready_now = 1'($urandom_range(0, 1));
                2'd2:    ready_now = (stall_tick % 3 == 0);
                default: ready_now = ($urandom_range(0, 9) != 0);
            endcase
            if (hold_left != 0) begin
                hold_left--;
                ready_now = 1'b0;
            end
            m_ready <= ready_now;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame construction and configuration helpers.
    // ------------------------------------------------------------------
    logic [7:0]  frame_buf [0:63];
    int unsigned bytes_queued  = 0;
    int unsigned frames_queued = 0;

    task automatic fill_const(input logic [7:0] value);
        for (int i = 0; i < 64; i++) frame_buf[i] = value;
    endtask

    // Lays out a header over random filler bytes. The fragment word is the
    // full 16 bits, so the flag bits get exercised too.
    task automatic build_frame(input logic [15:0] etype, input logic [7:0] proto,
                               input logic [15:0] frag_word,
                               input logic [31:0] ip_src, input logic [31:0] ip_dst,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [7:0] tcp_flags);
        for (int i = 0; i < 64; i++) frame_buf[i] = 8'($urandom);
        frame_buf[eihf_pkg::POS_ETYPE_FIRST] = etype[15:8];
        frame_buf[eihf_pkg::POS_ETYPE_LAST]  = etype[7:0];
        frame_buf[eihf_pkg::POS_VERSION_IHL] = 8'h45;
        frame_buf[eihf_pkg::POS_FRAG_HI]     = frag_word[15:8];
        frame_buf[eihf_pkg::POS_FRAG_LO]     = frag_word[7:0];
        frame_buf[eihf_pkg::POS_PROTO]       = proto;
        for (int k = 0; k < 4; k++) begin
            frame_buf[eihf_pkg::POS_IP_SRC_FIRST + k] = ip_src[31 - 8*k -: 8];
            frame_buf[eihf_pkg::POS_IP_DST_FIRST + k] = ip_dst[31 - 8*k -: 8];
        end
        frame_buf[eihf_pkg::POS_SPORT_LAST - 1] = sport[15:8];
        frame_buf[eihf_pkg::POS_SPORT_LAST]     = sport[7:0];
        frame_buf[eihf_pkg::POS_DPORT_LAST - 1] = dport[15:8];
        frame_buf[eihf_pkg::POS_DPORT_LAST]     = dport[7:0];
        frame_buf[eihf_pkg::POS_TCP_FLAGS]      = tcp_flags;
    endtask

    // Queues the first len bytes of frame_buf; bytes past the buffer are random.
    task automatic queue_frame(input int unsigned len);
        frame_byte_t fb;
        for (int unsigned i = 0; i < len; i++) begin
            fb.data = (i < 64) ? frame_buf[i] : 8'($urandom);
            fb.last = (i == len - 1);
            frame_bytes_todo.push_back(fb);
        end
        bytes_queued  += len;
        frames_queued++;
    endtask

    task automatic directed_frame(input logic [15:0] etype, input logic [7:0] proto,
                                  input logic [15:0] frag_word,
                                  input logic [31:0] ip_src, input logic [31:0] ip_dst,
                                  input logic [15:0] sport, input logic [15:0] dport,
                                  input logic [7:0] tcp_flags, input int unsigned len);
        build_frame(etype, proto, frag_word, ip_src, ip_dst, sport, dport, tcp_flags);
        queue_frame(len);
    endtask

    // Mostly well-formed IPv4 frames that tend to hit the active filters, so
    // that most of them get deep into the header; the rest is noise or cut short.
    task automatic queue_random_frame();
        int unsigned pick   = $urandom_range(0, 99);
        int unsigned proto_pick = $urandom_range(0, 9);
        int unsigned len_pick   = $urandom_range(0, 9);
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] frag_word;
        logic [31:0] ip_src, ip_dst;
        logic [15:0] sport, dport;
        etype = (pick < 92) ? eihf_pkg::ETHERTYPE_IPV4 : 16'($urandom);
        if (proto_pick < 4)      proto = eihf_pkg::PROTO_TCP;
        else if (proto_pick < 8) proto = eihf_pkg::PROTO_UDP;
        else                     proto = 8'($urandom);
        frag_word = ($urandom_range(0, 6) == 0) ? 16'($urandom)
                                               : {3'($urandom), 13'd0};
        ip_src = ($urandom_range(0, 3) != 0) ? rule_ip_source : $urandom;
        ip_dst = ($urandom_range(0, 3) != 0) ? rule_ip_dest : $urandom;
        sport  = ($urandom_range(0, 3) != 0) ? rule_sport : 16'($urandom);
        dport  = ($urandom_range(0, 3) != 0) ? rule_dport : 16'($urandom);
        build_frame(etype, proto, frag_word, ip_src, ip_dst, sport, dport, 8'($urandom));
        if (pick >= 96)
            for (int i = 0; i < 64; i++) frame_buf[i] = 8'($urandom);
        if (len_pick < 2)       queue_frame($urandom_range(1, 40));
        else if (len_pick == 2) queue_frame($urandom_range(64, 100));
        else                    queue_frame($urandom_range(40, 56));
    endtask

    // One register write; the predictor's copy changes with the handshake.
    task automatic write_filter_reg(input logic [7:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            eihf_pkg::CFG_IP_SOURCE_MATCH:   rule_ip_source = value;
            eihf_pkg::CFG_IP_DEST_MATCH:     rule_ip_dest   = value;
            eihf_pkg::CFG_SOURCE_PORT_MATCH: rule_sport     = value[15:0];
            eihf_pkg::CFG_DEST_PORT_MATCH:   rule_dport     = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_filters(input logic [31:0] ip_src, input logic [31:0] ip_dst,
                               input logic [31:0] sport, input logic [31:0] dport);
        write_filter_reg(eihf_pkg::CFG_IP_SOURCE_MATCH, ip_src);
        write_filter_reg(eihf_pkg::CFG_IP_DEST_MATCH, ip_dst);
        write_filter_reg(eihf_pkg::CFG_SOURCE_PORT_MATCH, sport);
        write_filter_reg(eihf_pkg::CFG_DEST_PORT_MATCH, dport);
    endtask

    // Idle means every queued byte is sent and every result is in.
    task automatic wait_idle();
        while (!(frame_bytes_todo.size() == 0 && !s_valid && expected_headers.size() == 0))
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_active_ip();
        return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endfunction

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned byte_mark;

        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed frames with every filter off.
        set_filters(32'd0, 32'd0, 32'd0, 32'd0);
        fill_const(8'hFF);
        queue_frame(1);       // a single byte: truncated before any check
        fill_const(8'h00);
        queue_frame(20);      // ethertype zero, nothing captured past it
        fill_const(8'hFF);
        queue_frame(66);      // bad ethertype on a long frame past the counter limit
        fill_const(8'hFF);
        queue_frame(13);      // ends one byte short of the ethertype check
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_UDP, 16'h4000,
                       32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 16'h0000, 8'h00, 40);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h0000,
                       $urandom, $urandom, 16'h0050, 16'hC001, 8'h12, 48);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'hE000,
                       $urandom, $urandom, 16'hFFFF, 16'hFFFF, 8'hED, 48);
        // TCP frame cut one byte before its flags.
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h0000,
                       $urandom, $urandom, 16'($urandom), 16'($urandom), 8'h12, 47);
        // Non-L4 protocol wins over a nonzero fragment offset.
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, 8'd1, 16'h1FFF, $urandom, $urandom,
                       16'($urandom), 16'($urandom), 8'($urandom), 34);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h0001,
                       $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom), 40);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, 8'hFF, 16'h0000, $urandom, $urandom,
                       16'($urandom), 16'($urandom), 8'($urandom), 34);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_UDP, 16'h0000,
                       $urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom), 66);
        wait_idle();

        // Directed frames against active filters. The source port write carries junk
        // in the upper half, and the two stray indexes must change nothing.
        set_filters(32'h0A010203, 32'hC0A80164, 32'hBEEF1234, 32'h00005678);
        write_filter_reg(CFG_INDEX_UNUSED_LO, 32'hFFFFFFFF);
        write_filter_reg(CFG_INDEX_UNUSED_HI, 32'hFFFFFFFF);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h0000,
                       32'h0A010203, 32'hC0A80164, 16'h1234, 16'h5678, 8'h10, 48);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_UDP, 16'h0000,
                       32'h0A010203, 32'hC0A80164, 16'h1234, 16'h5678, 8'h00, 40);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h0000,
                       32'h0A010204, 32'hC0A80164, 16'h1234, 16'h5678, 8'h12, 30);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_UDP, 16'h0000,
                       32'h0A010203, 32'hC0A80165, 16'h1234, 16'h5678, 8'h00, 34);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_UDP, 16'h0000,
                       32'h0A010203, 32'hC0A80164, 16'h1235, 16'h5678, 8'h00, 36);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h0000,
                       32'h0A010203, 32'hC0A80164, 16'h1234, 16'h5679, 8'h12, 38);
        directed_frame(eihf_pkg::ETHERTYPE_IPV4, eihf_pkg::PROTO_TCP, 16'h2100,
                       32'h0A010203, 32'hC0A80164, 16'h1234, 16'h5678, 8'h12, 34);
        wait_idle();

        // Random traffic under a series of filter settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_filters(32'd0, 32'd0, 32'd0, 32'd0);
                1: set_filters(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
                2: set_filters(random_active_ip(), random_active_ip(),
                               $urandom_range(1, 65535), $urandom_range(1, 65535));
                // A zero octet switches the address filter off.
                3: set_filters({8'($urandom), 8'h00, 16'($urandom)}, $urandom,
                               32'd0, $urandom);
                4: set_filters($urandom, $urandom, $urandom, $urandom);
                default: set_filters(random_active_ip(), 32'd0, $urandom, 32'd0);
            endcase
            byte_mark = bytes_queued;
            while (bytes_queued - byte_mark < 24)
                queue_random_frame();
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
rtl/core/eihf_pkg.sv
rtl/core/eth_ipv4_l4_header_filter_core.sv
rtl/core/eihf_checker.sv
tb/testbench.sv
